/* hdl/gjk_pkg.sv */
// Package for the convex hull intersection block: widths, codes, the sequencer
// state type and the record that travels along the multiply-accumulate chain.
// Depends on nothing; every other file of the block imports it.
package gjk_pkg;

    // Fixed field widths.
    localparam int COORD_BITS = 10;
    localparam int OFF_BITS   = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int ITERS_W    = 7;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_ITER_DEF   = 64;

    // Placed vertex, Minkowski point, narrow vector, cross result, wide vector, sum.
    localparam int PT_W = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 1;
    localparam int MK_W = PT_W + 1;
    localparam int NW   = MK_W + 2;
    localparam int CR_W = 2 * NW + 1;
    localparam int DW   = NW + CR_W + 2;
    localparam int AW   = DW + NW + 2;

    typedef logic signed [NW-1:0] nval_t;
    typedef logic signed [DW-1:0] dval_t;
    typedef logic signed [AW-1:0] aval_t;
    typedef nval_t nvec_t [3];
    typedef dval_t dvec_t [3];

    // One request moving down the chain: running sum and the three operand pairs.
    typedef struct {
        logic  vld;
        aval_t acc;
        dval_t x [3];
        nval_t y [3];
    } chain_t;

    // Input commands.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD_A = 2'd1;
    localparam logic [1:0] CMD_ADD_B = 2'd2;
    localparam logic [1:0] CMD_RUN   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_SEPARATED   = 2'd0;
    localparam logic [1:0] ST_INTERSECT   = 2'd1;
    localparam logic [1:0] ST_ITER_LIMIT  = 2'd2;
    localparam logic [1:0] ST_EMPTY       = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFF_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_A_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_B_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_B_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_B_Z = 3'd5;

    // Simplex sizes.
    localparam logic [1:0] SZ_EMPTY = 2'd0;
    localparam logic [1:0] SZ_POINT = 2'd1;
    localparam logic [1:0] SZ_LINE  = 2'd2;
    localparam logic [1:0] SZ_TRI   = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE, S_SUPA, S_SUPB, S_EXEC, S_SIGN, S_TRI1, S_TRI2, S_ITER,
        S_ABC2, S_FACE, S_T1, S_T1D, S_T2, S_T2D, S_T3D,
        S_ABC3, S_Q1, S_Q2, S_Q2D, S_Q3, S_Q3D
    } state_t;

    // Sign-extend a narrow value to the wide operand width.
    function automatic dval_t widen(nval_t v);
        return {{(DW-NW){v[NW-1]}}, v};
    endfunction

endpackage

/* hdl/gjk_cell.sv */
// One multiply-accumulate cell of the chain: adds the product of its own lane
// to the running sum and hands the whole request to the next cell.
// Depends on gjk_pkg.
module gjk_cell #(
    parameter int LANE = 0,
    parameter int TAGW = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gjk_pkg::chain_t   chain_in,
    input  logic [TAGW-1:0]   tag_in,
    output gjk_pkg::chain_t   chain_out,
    output logic [TAGW-1:0]   tag_out
);
    import gjk_pkg::*;

    logic signed [DW+NW-1:0] prod;
    chain_t                  cell_next;
    chain_t                  cell_reg;
    logic                    vld_reg;
    logic [TAGW-1:0]         tag_reg;

    // Product of this lane and the new running sum.
    always_comb
    begin
        prod = chain_in.x[LANE] * chain_in.y[LANE];
        cell_next = chain_in;
        cell_next.acc = chain_in.acc + {{(AW-DW-NW){prod[DW+NW-1]}}, prod};
    end

    // Valid flag is control and gets reset; the payload does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= cell_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        tag_reg  <= tag_in;
    end

    // The outgoing request carries the reset valid flag over the payload copy.
    always_comb
    begin
        chain_out = cell_reg;
        chain_out.vld = vld_reg;
    end

    assign tag_out = tag_reg;

endmodule

/* hdl/gjk_chain.sv */
// Row of three multiply-accumulate cells, one per vector lane; a request that
// enters gives a three-term sum of products once it has passed all three cells.
// Depends on gjk_pkg and gjk_cell.
module gjk_chain #(
    parameter int TAGW = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gjk_pkg::chain_t   chain_in,
    input  logic [TAGW-1:0]   tag_in,
    output gjk_pkg::chain_t   chain_out,
    output logic [TAGW-1:0]   tag_out
);
    import gjk_pkg::*;

    chain_t          link [4];
    logic [TAGW-1:0] tlink [4];

    assign link[0]  = chain_in;
    assign tlink[0] = tag_in;

    // Each cell hands its sum and operands to its neighbor every cycle.
    for (genvar g = 0; g < 3; g++)
    begin : g_cell
        gjk_cell #(
            .LANE (g),
            .TAGW (TAGW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .chain_in  (link[g]),
            .tag_in    (tlink[g]),
            .chain_out (link[g+1]),
            .tag_out   (tlink[g+1])
        );
    end

    assign chain_out = link[3];
    assign tag_out   = tlink[3];

endmodule

/* hdl/gjk_convex_hull_intersection.sv */
// GJK intersection test for two convex hulls of integer points, each shifted
// by its own three offset registers. Clear and add-vertex requests are taken
// one per cycle while the sequencer is idle. A run request performs, per GJK
// iteration, the two support searches, then dot and cross products (at most
// 13 such operations in the longest tetrahedron path) and control steps; a
// run ends after at most MAX_ITER iterations. All products go through one
// three-cell multiply-accumulate chain that both searches and the simplex
// math share. A run on an empty hull answers with the empty status and no
// search. Depends on gjk_pkg, gjk_chain and gjk_cell.
module gjk_convex_hull_intersection #(
    parameter int MAX_POINTS = gjk_pkg::MAX_POINTS_DEF,
    parameter int MAX_ITER   = gjk_pkg::MAX_ITER_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gjk_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gjk_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            command,
    input  logic signed [gjk_pkg::COORD_BITS-1:0] vx,
    input  logic signed [gjk_pkg::COORD_BITS-1:0] vy,
    input  logic signed [gjk_pkg::COORD_BITS-1:0] vz,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            status,
    output logic [gjk_pkg::ITERS_W-1:0]           iterations_used
);
    import gjk_pkg::*;

    localparam int IDXW = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int ITW  = $clog2(MAX_ITER + 1);
    localparam int VW   = 3 * COORD_BITS;

    // Hull stores.
    logic [VW-1:0] mem_a [MAX_POINTS];
    logic [VW-1:0] mem_b [MAX_POINTS];
    logic [VW-1:0] rda_reg, rdb_reg;

    // Control state.
    state_t          state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0]   cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [ITW-1:0]  it_reg, it_next;
    logic [1:0]      size_reg, size_next;
    logic            tet_reg, tet_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic            rdv_reg, rdv_next;
    logic [IDXW-1:0] rdtag_reg, rdtag_next;
    logic [1:0]      ecnt_reg, ecnt_next;
    logic            out_vld_reg, out_vld_next;

    // Payload state.
    logic signed [OFF_BITS-1:0] off_reg [6];
    dvec_t dir_reg, dir_next, abc_reg, abc_next, r_reg, r_next, opu_reg, opu_next;
    nvec_t b_reg, b_next, c_reg, c_next, d_reg, d_next, a_reg, a_next;
    nvec_t ao_reg, ao_next, ab_reg, ab_next, ac_reg, ac_next, ad_reg, ad_next;
    nvec_t tu_reg, tu_next, opv_reg, opv_next, ba_reg, ba_next, besty_reg, besty_next;
    aval_t s_reg, s_next, best_reg, best_next;
    logic  opdot_reg, opdot_next, opneg_reg, opneg_next;
    logic [1:0]         status_reg, status_next;
    logic [ITERS_W-1:0] iters_reg, iters_next;

    // Chain connections.
    chain_t          chin, chout;
    logic [IDXW-1:0] tagin, tagout;

    logic            in_acc, out_acc, wr_a, wr_b, sup_last, sup_win, exec_done, produce;
    logic            s_pos, s_neg;
    logic [CW-1:0]   cnt_cur, last_idx;
    logic [1:0]      lj, lk;
    nvec_t           chosen, amk, ab_c, ac_c, ao_c, ad_c;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_vld_reg && command == CMD_RUN);
    assign wr_a = in_acc && command == CMD_ADD_A && cnt_a_reg < CW'(MAX_POINTS);
    assign wr_b = in_acc && command == CMD_ADD_B && cnt_b_reg < CW'(MAX_POINTS);
    assign s_neg = s_reg[AW-1];
    assign s_pos = !s_reg[AW-1] && (s_reg != '0);

    // Hull memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cnt_a_reg[IDXW-1:0]] <= {vz, vy, vx};
        end
        if (wr_b)
        begin
            mem_b[cnt_b_reg[IDXW-1:0]] <= {vz, vy, vx};
        end
        rda_reg <= mem_a[iss_reg[IDXW-1:0]];
        rdb_reg <= mem_b[iss_reg[IDXW-1:0]];
    end

    // Offset registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                off_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFF_A_X: off_reg[0] <= cfg_data;
                REG_OFF_A_Y: off_reg[1] <= cfg_data;
                REG_OFF_A_Z: off_reg[2] <= cfg_data;
                REG_OFF_B_X: off_reg[3] <= cfg_data;
                REG_OFF_B_Y: off_reg[4] <= cfg_data;
                REG_OFF_B_Z: off_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared chain.
    gjk_chain #(
        .TAGW (IDXW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .chain_in  (chin),
        .tag_in    (tagin),
        .chain_out (chout),
        .tag_out   (tagout)
    );

    // Cross product lanes for the component being issued.
    always_comb
    begin
        case (ecnt_reg)
            2'd0:    begin lj = 2'd1; lk = 2'd2; end
            2'd1:    begin lj = 2'd2; lk = 2'd0; end
            default: begin lj = 2'd0; lk = 2'd1; end
        endcase
    end

    // Chain feed: vertices during support search, operands during an operation.
    always_comb
    begin
        logic [VW-1:0] rd;
        rd = (state_reg == S_SUPB) ? rdb_reg : rda_reg;
        chin.vld = 1'b0;
        chin.acc = '0;
        tagin = '0;
        for (int i = 0; i < 3; i++)
        begin
            chin.x[i] = '0;
            chin.y[i] = '0;
        end
        if (state_reg == S_SUPA || state_reg == S_SUPB)
        begin
            chin.vld = rdv_reg;
            tagin = rdtag_reg;
            for (int i = 0; i < 3; i++)
            begin
                chin.x[i] = (state_reg == S_SUPB) ? -dir_reg[i] : dir_reg[i];
                chin.y[i] = {{(NW-COORD_BITS){rd[i*COORD_BITS+COORD_BITS-1]}},
                             rd[i*COORD_BITS +: COORD_BITS]};
            end
        end
        else if (state_reg == S_EXEC)
        begin
            tagin = IDXW'(ecnt_reg);
            if (opdot_reg)
            begin
                chin.vld = (ecnt_reg == 2'd0);
                chin.x = opu_reg;
                chin.y = opv_reg;
            end
            else
            begin
                chin.vld = (ecnt_reg != 2'd3);
                chin.x[1] = opneg_reg ? -opu_reg[lj] : opu_reg[lj];
                chin.y[1] = opv_reg[lk];
                chin.x[2] = opneg_reg ? opu_reg[lk] : -opu_reg[lk];
                chin.y[2] = opv_reg[lj];
            end
        end
    end

    // Support search bookkeeping and the new Minkowski point.
    always_comb
    begin
        cnt_cur  = (state_reg == S_SUPB) ? cnt_b_reg : cnt_a_reg;
        last_idx = cnt_cur - CW'(1);
        sup_win  = chout.vld && (tagout == '0 || chout.acc > best_reg);
        sup_last = chout.vld && (tagout == last_idx[IDXW-1:0]);
        for (int i = 0; i < 3; i++)
        begin
            chosen[i] = sup_win ? chout.y[i] : besty_reg[i];
        end
        exec_done = chout.vld && (opdot_reg || tagout[1:0] == 2'd2);
        for (int i = 0; i < 3; i++)
        begin
            amk[i] = (ba_reg[i] + {{(NW-OFF_BITS){off_reg[i][OFF_BITS-1]}}, off_reg[i]})
                   - (chosen[i] + {{(NW-OFF_BITS){off_reg[i+3][OFF_BITS-1]}},
                      off_reg[i+3]});
            ao_c[i] = -a_reg[i];
            ab_c[i] = b_reg[i] - a_reg[i];
            ac_c[i] = c_reg[i] - a_reg[i];
            ad_c[i] = d_reg[i] - a_reg[i];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && command == CMD_RUN && cnt_a_reg != '0 && cnt_b_reg != '0)
                begin
                    state_next = S_SUPA;
                end
            end
            S_SUPA: if (sup_last) state_next = S_SUPB;
            S_SUPB:
            begin
                if (sup_last)
                begin
                    state_next = S_EXEC;
                    ret_next = S_SIGN;
                end
            end
            S_EXEC: if (exec_done) state_next = ret_reg;
            S_SIGN:
            begin
                if (s_neg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    case (size_reg)
                        SZ_EMPTY: state_next = S_ITER;
                        SZ_POINT: begin state_next = S_EXEC; ret_next = S_TRI1; end
                        SZ_LINE:  begin state_next = S_EXEC; ret_next = S_ABC2; end
                        default:  begin state_next = S_EXEC; ret_next = S_ABC3; end
                    endcase
                end
            end
            S_TRI1: begin state_next = S_EXEC; ret_next = S_TRI2; end
            S_TRI2: state_next = S_ITER;
            S_ITER: state_next = (it_reg == ITW'(MAX_ITER)) ? S_IDLE : S_SUPA;
            S_ABC2: state_next = S_FACE;
            S_FACE: begin state_next = S_EXEC; ret_next = S_T1; end
            S_T1:   begin state_next = S_EXEC; ret_next = S_T1D; end
            S_T1D:
            begin
                state_next = S_EXEC;
                ret_next = s_pos ? S_TRI1 : S_T2;
            end
            S_T2:   begin state_next = S_EXEC; ret_next = S_T2D; end
            S_T2D:
            begin
                if (s_pos)
                begin
                    state_next = S_EXEC;
                    ret_next = S_TRI1;
                end
                else if (tet_reg)
                begin
                    state_next = S_ITER;
                end
                else
                begin
                    state_next = S_EXEC;
                    ret_next = S_T3D;
                end
            end
            S_T3D:  state_next = S_ITER;
            S_ABC3: begin state_next = S_EXEC; ret_next = S_Q1; end
            S_Q1:
            begin
                if (s_pos)
                begin
                    state_next = S_FACE;
                end
                else
                begin
                    state_next = S_EXEC;
                    ret_next = S_Q2;
                end
            end
            S_Q2:   begin state_next = S_EXEC; ret_next = S_Q2D; end
            S_Q2D:
            begin
                if (s_pos)
                begin
                    state_next = S_FACE;
                end
                else
                begin
                    state_next = S_EXEC;
                    ret_next = S_Q3;
                end
            end
            S_Q3:   begin state_next = S_EXEC; ret_next = S_Q3D; end
            S_Q3D:  state_next = s_pos ? S_FACE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs of each state.
    always_comb
    begin
        cnt_a_next = cnt_a_reg; cnt_b_next = cnt_b_reg;
        it_next = it_reg; size_next = size_reg; tet_next = tet_reg;
        iss_next = iss_reg; rdv_next = 1'b0; rdtag_next = rdtag_reg;
        ecnt_next = ecnt_reg;
        dir_next = dir_reg; abc_next = abc_reg; r_next = r_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg; a_next = a_reg;
        ao_next = ao_reg; ab_next = ab_reg; ac_next = ac_reg; ad_next = ad_reg;
        tu_next = tu_reg; ba_next = ba_reg; besty_next = besty_reg;
        s_next = s_reg; best_next = best_reg;
        opu_next = opu_reg; opv_next = opv_reg;
        opdot_next = opdot_reg; opneg_next = opneg_reg;
        produce = 1'b0; status_next = status_reg; iters_next = iters_reg;

        // Hull loads.
        if (in_acc && command == CMD_CLEAR)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
        if (wr_a) cnt_a_next = cnt_a_reg + CW'(1);
        if (wr_b) cnt_b_next = cnt_b_reg + CW'(1);

        // Issue vertices to the chain and keep the first maximum.
        if (state_reg == S_SUPA || state_reg == S_SUPB)
        begin
            if (iss_reg < cnt_cur)
            begin
                rdv_next = 1'b1;
                rdtag_next = iss_reg[IDXW-1:0];
                iss_next = iss_reg + CW'(1);
            end
            if (sup_win)
            begin
                best_next = chout.acc;
                besty_next = chout.y;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && command == CMD_RUN)
                begin
                    if (cnt_a_reg == '0 || cnt_b_reg == '0)
                    begin
                        produce = 1'b1;
                        status_next = ST_EMPTY;
                        iters_next = '0;
                    end
                    else
                    begin
                        it_next = ITW'(1);
                        size_next = SZ_EMPTY;
                        iss_next = '0;
                        dir_next[0] = DW'(1);
                        dir_next[1] = '0;
                        dir_next[2] = '0;
                    end
                end
            end
            S_SUPA:
            begin
                if (sup_last)
                begin
                    ba_next = chosen;
                    iss_next = '0;
                end
            end
            S_SUPB:
            begin
                if (sup_last)
                begin
                    a_next = amk;
                    opdot_next = 1'b1; opneg_next = 1'b0; ecnt_next = '0;
                    opu_next = dir_reg; opv_next = amk;
                end
            end
            S_EXEC:
            begin
                if (chin.vld)
                begin
                    ecnt_next = ecnt_reg + 2'd1;
                end
                if (chout.vld)
                begin
                    if (opdot_reg)
                    begin
                        s_next = chout.acc;
                    end
                    else
                    begin
                        r_next[tagout[1:0]] = chout.acc[DW-1:0];
                    end
                end
            end
            S_SIGN:
            begin
                if (s_neg)
                begin
                    produce = 1'b1;
                    status_next = ST_SEPARATED;
                    iters_next = ITERS_W'(it_reg);
                end
                else
                begin
                    ao_next = ao_c;
                    tet_next = (size_reg == SZ_TRI);
                    opdot_next = 1'b0; opneg_next = 1'b0; ecnt_next = '0;
                    case (size_reg)
                        SZ_EMPTY:
                        begin
                            b_next = a_reg;
                            for (int i = 0; i < 3; i++) dir_next[i] = widen(ao_c[i]);
                            size_next = SZ_POINT;
                        end
                        SZ_POINT:
                        begin
                            ab_next = ab_c; tu_next = ab_c;
                            c_next = b_reg; b_next = a_reg;
                            size_next = SZ_LINE;
                            for (int i = 0; i < 3; i++) opu_next[i] = widen(ab_c[i]);
                            opv_next = ao_c;
                        end
                        default:
                        begin
                            ab_next = ab_c; ac_next = ac_c;
                            for (int i = 0; i < 3; i++) opu_next[i] = widen(ab_c[i]);
                            opv_next = ac_c;
                        end
                    endcase
                end
            end
            S_TRI1:
            begin
                opdot_next = 1'b0; opneg_next = 1'b0; ecnt_next = '0;
                opu_next = r_reg; opv_next = tu_reg;
            end
            S_TRI2: dir_next = r_reg;
            S_ITER:
            begin
                if (it_reg == ITW'(MAX_ITER))
                begin
                    produce = 1'b1;
                    status_next = ST_ITER_LIMIT;
                    iters_next = ITERS_W'(MAX_ITER);
                end
                else
                begin
                    it_next = it_reg + ITW'(1);
                    iss_next = '0;
                end
            end
            S_ABC2: abc_next = r_reg;
            S_FACE:
            begin
                opdot_next = 1'b0; opneg_next = 1'b1; ecnt_next = '0;
                opu_next = abc_reg; opv_next = ab_reg;
            end
            S_T1, S_T2, S_Q2, S_Q3:
            begin
                opdot_next = 1'b1; opneg_next = 1'b0; ecnt_next = '0;
                opu_next = r_reg; opv_next = ao_reg;
            end
            S_T1D:
            begin
                opdot_next = 1'b0; opneg_next = 1'b0; ecnt_next = '0;
                if (s_pos)
                begin
                    c_next = b_reg; b_next = a_reg; tu_next = ab_reg;
                    size_next = SZ_LINE;
                    for (int i = 0; i < 3; i++) opu_next[i] = widen(ab_reg[i]);
                    opv_next = ao_reg;
                end
                else
                begin
                    opu_next = abc_reg; opv_next = ac_reg;
                end
            end
            S_T2D:
            begin
                ecnt_next = '0; opneg_next = 1'b0;
                if (s_pos)
                begin
                    b_next = a_reg; tu_next = ac_reg;
                    size_next = SZ_LINE;
                    opdot_next = 1'b0;
                    for (int i = 0; i < 3; i++) opu_next[i] = widen(ac_reg[i]);
                    opv_next = ao_reg;
                end
                else if (tet_reg)
                begin
                    d_next = c_reg; c_next = b_reg; b_next = a_reg;
                    dir_next = abc_reg;
                    size_next = SZ_TRI;
                end
                else
                begin
                    opdot_next = 1'b1;
                    opu_next = abc_reg; opv_next = ao_reg;
                end
            end
            S_T3D:
            begin
                if (s_pos)
                begin
                    d_next = c_reg; c_next = b_reg;
                    dir_next = abc_reg;
                end
                else
                begin
                    d_next = b_reg;
                    for (int i = 0; i < 3; i++) dir_next[i] = -abc_reg[i];
                end
                b_next = a_reg;
                size_next = SZ_TRI;
            end
            S_ABC3:
            begin
                abc_next = r_reg;
                opdot_next = 1'b1; opneg_next = 1'b0; ecnt_next = '0;
                opu_next = r_reg; opv_next = ao_reg;
            end
            S_Q1:
            begin
                if (!s_pos)
                begin
                    ad_next = ad_c;
                    opdot_next = 1'b0; opneg_next = 1'b0; ecnt_next = '0;
                    for (int i = 0; i < 3; i++) opu_next[i] = widen(ac_reg[i]);
                    opv_next = ad_c;
                end
            end
            S_Q2D:
            begin
                if (s_pos)
                begin
                    b_next = c_reg; c_next = d_reg;
                    ab_next = ac_reg; ac_next = ad_reg; abc_next = r_reg;
                end
                else
                begin
                    opdot_next = 1'b0; opneg_next = 1'b0; ecnt_next = '0;
                    for (int i = 0; i < 3; i++) opu_next[i] = widen(ad_reg[i]);
                    opv_next = ab_reg;
                end
            end
            S_Q3D:
            begin
                if (s_pos)
                begin
                    c_next = b_reg; b_next = d_reg;
                    ac_next = ab_reg; ab_next = ad_reg; abc_next = r_reg;
                end
                else
                begin
                    produce = 1'b1;
                    status_next = ST_INTERSECT;
                    iters_next = ITERS_W'(it_reg);
                end
            end
            default: ;
        endcase

        // Output register: a new result only lands in a free slot.
        if (produce)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            it_reg      <= '0;
            size_reg    <= SZ_EMPTY;
            tet_reg     <= 1'b0;
            iss_reg     <= '0;
            rdv_reg     <= 1'b0;
            ecnt_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            it_reg      <= it_next;
            size_reg    <= size_next;
            tet_reg     <= tet_next;
            iss_reg     <= iss_next;
            rdv_reg     <= rdv_next;
            ecnt_reg    <= ecnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rdtag_reg  <= rdtag_next;
        dir_reg    <= dir_next;
        abc_reg    <= abc_next;
        r_reg      <= r_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        a_reg      <= a_next;
        ao_reg     <= ao_next;
        ab_reg     <= ab_next;
        ac_reg     <= ac_next;
        ad_reg     <= ad_next;
        tu_reg     <= tu_next;
        ba_reg     <= ba_next;
        besty_reg  <= besty_next;
        s_reg      <= s_next;
        best_reg   <= best_next;
        opu_reg    <= opu_next;
        opv_reg    <= opv_next;
        opdot_reg  <= opdot_next;
        opneg_reg  <= opneg_next;
        status_reg <= status_next;
        iters_reg  <= iters_next;
    end

    assign out_valid       = out_vld_reg;
    assign status          = status_reg;
    assign iterations_used = iters_reg;

`ifndef SYNTHESIS
    // A finished run never lands on a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (!out_vld_reg || !out_stall))
        else $error("result produced while output slot is occupied");

    // Hull fill counts never pass the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CW'(MAX_POINTS)) && (cnt_b_reg <= CW'(MAX_POINTS)))
        else $error("hull count beyond store depth");

    // The iteration counter stays in range while a run is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (it_reg >= ITW'(1) && it_reg <= ITW'(MAX_ITER)))
        else $error("iteration counter out of range during a run");

    // The chain only returns sums while a search or an operation is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        chout.vld |-> (state_reg == S_SUPA || state_reg == S_SUPB || state_reg == S_EXEC))
        else $error("chain output with nobody waiting for it");
`endif

endmodule
